>>> hdl/sigmoid_gated_multivector_scale_defines.svh
// ---------------------------------------------------------------------------
// Sigmoid gated multivector scale: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SIGMOID_GATED_MULTIVECTOR_SCALE_DEFINES_SVH
`define SIGMOID_GATED_MULTIVECTOR_SCALE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGMS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/sgms_pkg.sv
// ---------------------------------------------------------------------------
// Sigmoid gated multivector scale: package
// Shared constants, types and the elaboration-time sigmoid table builder.
// ---------------------------------------------------------------------------
package sgms_pkg;

   localparam int MUL_W         = 32;
   localparam int DATA_W        = 32;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 5;
   localparam int MAX_FULL_DEF  = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int SIG_DEPTH_DEF = 256;
   localparam int SIG_DEPTH_MAX = 1024;

   localparam logic [CSR_ADDR_W-1:0] CSR_AGG_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PACK_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FULL_COUNT = 2'd2;

   localparam logic [1:0] AGG_WEIGHTED = 2'd0;
   localparam logic [1:0] AGG_SUM      = 2'd1;
   localparam logic [1:0] AGG_MEAN     = 2'd2;

   localparam logic [3:0] PACK_FOUR = 4'd4;

   localparam logic [DATA_W-1:0] PROD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] PROD_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WMUL,
      ST_ACC,
      ST_BIAS,
      ST_RANGE,
      ST_SMUL,
      ST_LOOK,
      ST_IMUL,
      ST_IFIN,
      ST_FMUL,
      ST_FOUT
   } sgms_state_type;

   typedef struct packed {
      logic                    en;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } sgms_mul_req_type;

   typedef logic [31:0] sig_tab_type [0:SIG_DEPTH_MAX];

   // Restoring division, evaluated only while the table constant is elaborated.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid samples at x = -8 + 16 i / depth. The exponentials are built by
   // repeated Q32 multiplication by e^(-1/depth), taken from a truncated series.
   function automatic sig_tab_type build_sig_tab(input int depth, input int frac);
      sig_tab_type tab;
      logic [63:0] d, h, term, pos, neg, r, e, u, den, spos, one, span, hi_pos, lo_pos;
      tab  = '{default: '0};
      d    = 64'(depth);
      h    = udiv64(64'd1 << 32, d);
      term = 64'd1 << 32;
      pos  = 64'd1 << 32;
      neg  = '0;
      one  = 64'd1 << frac;
      span = d << 3;
      for (int n = 1; n <= 8; n++) begin
         term = udiv64((term * h) >> 32, 64'(n));
         if (n[0])
            neg = neg + term;
         else
            pos = pos + term;
      end
      r = pos - neg;
      e = 64'd1 << 32;
      for (int ui = 0; ui <= 8 * depth; ui++) begin
         u      = 64'(ui);
         den    = (64'd1 << 32) + e;
         spos   = udiv64((one << 32) + (den >> 1), den);
         hi_pos = span + u;
         lo_pos = span - u;
         if (hi_pos[3:0] == 4'd0 && (hi_pos >> 4) <= d)
            tab[int'(hi_pos >> 4)] = spos[31:0];
         if (lo_pos[3:0] == 4'd0)
            tab[int'(lo_pos >> 4)] = 32'(one - spos);
         e = (e * r) >> 32;
      end
      return tab;
   endfunction

endpackage

>>> hdl/sigmoid_gated_multivector_scale.sv
// ---------------------------------------------------------------------------
// Sigmoid gated multivector scale: top level
// Per channel gate from packed components through an interpolated sigmoid,
// then scaling of the full components by that gate.
// ---------------------------------------------------------------------------
// A full request is scaled in the shared multiplier, and its registered product
// goes into the result register; the next request is taken once the result
// register is free; a waiting result only holds the block in its last step.
// A packed request is accumulated, after a multiply in weighted mode; the final
// one of a channel adds the bias (weighted mode), checks the range and, inside
// the window, scales, looks up and interpolates through the one shared multiplier.
// Reset is synchronous: registers to defaults, the gate to zero, the block idle.
// ---------------------------------------------------------------------------
`include "sigmoid_gated_multivector_scale_defines.svh"

module sigmoid_gated_multivector_scale
   import sgms_pkg::*;
#(
   parameter int MAX_FULL            = MAX_FULL_DEF,
   parameter int FRAC_BITS           = FRAC_BITS_DEF,
   parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,   // value [31:0], weight [63:32], bias [95:64]
   input  logic [1:0]            req_tuser,   // mode [0], batch_end [1]
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // product [31:0]
   output logic                  rsp_tlast,   // channel_last
   output logic [0:0]            rsp_tuser,   // batch_last [0]
   // Register writes.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Gate width: one is 1 << FRAC_BITS, so one extra bit holds it.
   localparam int GW = FRAC_BITS + 1;
   // Offset into the [-8,8) window, 16 << FRAC_BITS wide.
   localparam int OW = FRAC_BITS + 4;
   localparam int IW = $clog2(SIGMOID_TABLE_DEPTH + 1);
   localparam int NW = $clog2(MAX_FULL + 1);

   localparam logic signed [63:0] LIM     = 64'sd8 <<< FRAC_BITS;
   localparam logic signed [63:0] SEGW_M1 = (64'sd16 <<< FRAC_BITS) - 64'sd1;
   localparam logic [GW-1:0]      ONE     = {1'b1, {FRAC_BITS{1'b0}}};

   localparam sig_tab_type SIG_TAB = build_sig_tab(SIGMOID_TABLE_DEPTH, FRAC_BITS);
   localparam logic [GW-1:0] GATE_LOW  = SIG_TAB[0][GW-1:0];
   localparam logic [GW-1:0] GATE_HIGH = SIG_TAB[SIGMOID_TABLE_DEPTH][GW-1:0];

   // Control state.
   sgms_state_type           state_ff, state_in;
   logic [1:0]               reduce_mode_ff, reduce_mode_in;
   logic [3:0]               pack_count_ff, pack_count_in;
   logic [4:0]               full_count_ff, full_count_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic [2:0]               packed_seen_ff, packed_seen_in;
   logic [GW-1:0]            gate_ff, gate_in;
   logic [NW-1:0]            full_seen_ff, full_seen_in;
   logic                     batch_seen_ff, batch_seen_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Payload.
   logic signed [31:0]       value_ff, value_in;
   logic signed [31:0]       weight_ff, weight_in;
   logic signed [31:0]       bias_ff, bias_in;
   logic [OW-1:0]            off_ff, off_in;
   logic [OW-1:0]            frac_ff, frac_in;
   logic [GW-1:0]            lo_ff, lo_in;
   logic signed [GW:0]       diff_ff, diff_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_user_ff, rsp_user_in;

   // Shared multiplier.
   sgms_mul_req_type         mul_req;
   logic signed [63:0]       mul_prod;

   // Datapath terms.
   logic                     req_accept;
   logic                     weighted;
   logic                     is_four;
   logic                     last_packed;
   logic signed [63:0]       addend;
   logic [64:0]              sum_wide;
   logic signed [63:0]       sat_sum;
   logic signed [63:0]       agg;
   logic signed [63:0]       off_full;
   logic                     below;
   logic                     above;
   logic [IW-1:0]            tab_idx;
   logic [IW-1:0]            tab_idx_hi;
   logic [GW-1:0]            tab_lo;
   logic [GW-1:0]            tab_hi;
   logic signed [63:0]       interp_q;
   logic [NW-1:0]            eff_n;
   logic                     clast;
   logic                     rsp_load;
   logic                     scale_fits;
   logic [DATA_W-1:0]        scale_val;

   sgms_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign weighted   = (reduce_mode_ff == AGG_WEIGHTED);
   assign is_four    = (pack_count_ff == PACK_FOUR);
   // Four or eight packed components close a channel's gate. A count left
   // beyond the fourth by a change of pack count closes it at once.
   assign last_packed = is_four ? (packed_seen_ff >= 3'd3) : (packed_seen_ff == 3'd7);

   // One saturating 64-bit adder serves the weighted terms, plain values and bias.
   always_comb begin
      if (state_ff == ST_BIAS) begin
         addend = {{32{bias_ff[31]}}, bias_ff};
      end else if (weighted) begin
         addend = mul_prod >>> FRAC_BITS;
      end else begin
         addend = {{32{value_ff[31]}}, value_ff};
      end
   end

   assign sum_wide = {acc_ff[63], acc_ff} + {addend[63], addend};

   always_comb begin
      if (sum_wide[64] != sum_wide[63]) begin
         sat_sum = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sum = sum_wide[63:0];
      end
   end

   // The mean is the sum shifted down by two or three, rounding towards
   // minus infinity.
   always_comb begin
      if (reduce_mode_ff == AGG_MEAN) begin
         agg = is_four ? (acc_ff >>> 2) : (acc_ff >>> 3);
      end else begin
         agg = acc_ff;
      end
   end

   assign below    = (agg < -LIM);
   assign above    = (agg >= LIM);
   assign off_full = agg + LIM;

   // After the scale step the product holds offset times depth; the top bits
   // select the segment and the low bits are the fraction within it.
   assign tab_idx    = mul_prod[FRAC_BITS+4 +: IW];
   assign tab_idx_hi = tab_idx + IW'(1);
   assign tab_lo     = SIG_TAB[tab_idx][GW-1:0];
   assign tab_hi     = SIG_TAB[tab_idx_hi][GW-1:0];

   // Interpolation step divides by the segment width with truncation towards
   // zero, so a negative product is biased up before the shift.
   assign interp_q = (mul_prod + (mul_prod[63] ? SEGW_M1 : 64'sd0)) >>> (FRAC_BITS + 4);

   // Full component count, a zero acting as one and large values clamped.
   always_comb begin
      if (full_count_ff == 5'd0) begin
         eff_n = NW'(1);
      end else if (full_count_ff > MAX_FULL) begin
         eff_n = NW'(MAX_FULL);
      end else begin
         eff_n = NW'(full_count_ff);
      end
   end

   assign clast = ({1'b0, full_seen_ff} + 1'b1) >= {1'b0, eff_n};

   // The scaled product fits when the bits above the result are all sign.
   assign scale_fits = (&mul_prod[63:FRAC_BITS+31]) || !(|mul_prod[63:FRAC_BITS+31]);
   assign scale_val  = scale_fits ? mul_prod[FRAC_BITS+31:FRAC_BITS]
                                  : (mul_prod[63] ? PROD_MIN : PROD_MAX);

   // The result register is loaded once it is empty or being drained.
   assign rsp_load = (state_ff == ST_FOUT) && (!rsp_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0])
                  state_in = ST_FMUL;
               else
                  state_in = weighted ? ST_WMUL : ST_ACC;
            end
         end
         ST_WMUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (!last_packed)
               state_in = ST_IDLE;
            else
               state_in = weighted ? ST_BIAS : ST_RANGE;
         end
         ST_BIAS:  state_in = ST_RANGE;
         ST_RANGE: state_in = (below || above) ? ST_IDLE : ST_SMUL;
         ST_SMUL:  state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_IMUL;
         ST_IMUL:  state_in = ST_IFIN;
         ST_IFIN:  state_in = ST_IDLE;
         ST_FMUL:  state_in = ST_FOUT;
         ST_FOUT:  state_in = rsp_load ? ST_IDLE : ST_FOUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and register updates.
   always_comb begin
      reduce_mode_in = reduce_mode_ff;
      pack_count_in  = pack_count_ff;
      full_count_in  = full_count_ff;
      acc_in         = acc_ff;
      packed_seen_in = packed_seen_ff;
      gate_in        = gate_ff;
      full_seen_in   = full_seen_ff;
      batch_seen_in  = batch_seen_ff;
      value_in       = value_ff;
      weight_in      = weight_ff;
      bias_in        = bias_ff;
      off_in         = off_ff;
      frac_in        = frac_ff;
      lo_in          = lo_ff;
      diff_in        = diff_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      mul_req        = '{en: 1'b0, a: value_ff, b: weight_ff};

      if (csr_we) begin
         unique case (csr_addr)
            CSR_AGG_MODE:   reduce_mode_in = csr_wdata[1:0];
            CSR_PACK_COUNT: pack_count_in  = csr_wdata[3:0];
            CSR_FULL_COUNT: full_count_in  = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in  = req_tdata[31:0];
               weight_in = req_tdata[63:32];
               bias_in   = req_tdata[95:64];
               if (req_tuser[1])
                  batch_seen_in = 1'b1;
            end
         end
         ST_WMUL: begin
            mul_req = '{en: 1'b1, a: value_ff, b: weight_ff};
         end
         ST_ACC: begin
            acc_in = sat_sum;
            if (!last_packed)
               packed_seen_in = packed_seen_ff + 3'd1;
         end
         ST_BIAS: begin
            acc_in = sat_sum;
         end
         ST_RANGE: begin
            acc_in         = '0;
            packed_seen_in = '0;
            off_in         = off_full[OW-1:0];
            if (below)
               gate_in = GATE_LOW;
            else if (above)
               gate_in = GATE_HIGH;
         end
         ST_SMUL: begin
            mul_req = '{en: 1'b1, a: 32'(off_ff), b: 32'(SIGMOID_TABLE_DEPTH)};
         end
         ST_LOOK: begin
            frac_in = mul_prod[OW-1:0];
            lo_in   = tab_lo;
            diff_in = $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
         end
         ST_IMUL: begin
            mul_req = '{en: 1'b1, a: 32'(diff_ff), b: 32'(frac_ff)};
         end
         ST_IFIN: begin
            gate_in = lo_ff + interp_q[GW-1:0];
         end
         ST_FMUL: begin
            mul_req = '{en: 1'b1, a: value_ff, b: 32'(gate_ff)};
         end
         ST_FOUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = scale_val;
               rsp_last_in  = clast;
               rsp_user_in  = clast && batch_seen_ff;
               if (clast) begin
                  full_seen_in  = '0;
                  batch_seen_in = 1'b0;
               end else begin
                  full_seen_in = full_seen_ff + NW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         reduce_mode_ff <= AGG_WEIGHTED;
         pack_count_ff  <= 4'd8;
         full_count_ff  <= 5'd8;
         acc_ff         <= '0;
         packed_seen_ff <= '0;
         gate_ff        <= '0;
         full_seen_ff   <= '0;
         batch_seen_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         reduce_mode_ff <= reduce_mode_in;
         pack_count_ff  <= pack_count_in;
         full_count_ff  <= full_count_in;
         acc_ff         <= acc_in;
         packed_seen_ff <= packed_seen_in;
         gate_ff        <= gate_in;
         full_seen_ff   <= full_seen_in;
         batch_seen_ff  <= batch_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      weight_ff   <= weight_in;
      bias_ff     <= bias_in;
      off_ff      <= off_in;
      frac_ff     <= frac_in;
      lo_ff       <= lo_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // The batch flag is only ever raised on the last result of a channel.
   `SGMS_ASSERT_SAME(a_batch_needs_last, rsp_tvalid && rsp_tuser[0], rsp_tlast,
                     "batch_last without channel_last")
   // A full request goes straight to the scaling multiply.
   `SGMS_ASSERT_NEXT(a_full_to_mul, req_tvalid && req_tready && req_tuser[0],
                     state_ff == ST_FMUL, "full request did not start scaling")
   // Interpolation never leaves the table's range, so the gate stays within one.
   `SGMS_ASSERT_SAME(a_gate_range, 1'b1, gate_ff <= ONE, "gate above one")

endmodule

>>> hdl/sgms_mul.sv
// ---------------------------------------------------------------------------
// Sigmoid gated multivector scale: shared multiplier
// Signed 32 by 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
module sgms_mul
   import sgms_pkg::*;
(
   input  logic                      clock,
   input  sgms_mul_req_type          mul_req,
   output logic signed [2*MUL_W-1:0] mul_prod
);

   logic signed [2*MUL_W-1:0] prod_ff;

   // The product only moves when the sequencer asks for it, so it can be
   // read again in later steps.
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= mul_req.a * mul_req.b;
      end
   end

   assign mul_prod = prod_ff;

endmodule
